FILE: rtl/core/sbsm_pkg.sv
// Shared types and constants of the serial bank switch mapper.
package sbsm_pkg;

	typedef enum logic [1:0] {
		OP_CPU_RD = 2'd0,
		OP_CPU_WR = 2'd1,
		OP_PPU_RD = 2'd2,
		OP_PPU_WR = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		TGT_NONE    = 2'd0,
		TGT_PRG_ROM = 2'd1,
		TGT_PRG_RAM = 2'd2,
		TGT_CHR     = 2'd3
	} target_t;

	typedef enum logic [1:0] {
		SEL_CONTROL = 2'd0,
		SEL_CHR0    = 2'd1,
		SEL_CHR1    = 2'd2,
		SEL_PRG     = 2'd3
	} reg_sel_t;

	localparam logic       REG_PRG_BANK_COUNT = 1'b0;
	localparam logic [5:0] PRG_BANK_COUNT_RST = 6'd2;
	localparam logic [4:0] CONTROL_RST        = 5'h0C;
	localparam logic [4:0] PRG_MODE3_BITS     = 5'h0C;
	localparam logic [4:0] CHR_HIGH_RST       = 5'd1;

	typedef struct packed {
		target_t     target;
		logic [18:0] mem_addr;
		logic        mem_write;
		logic [1:0]  mirroring;
	} result_t;

endpackage

FILE: rtl/core/sbsm_ctrl.sv
// Mapper registers, serial loader and address translation.
module sbsm_ctrl import sbsm_pkg::*; #(
	parameter int PRG_RAM_BYTES = 8192,
	parameter int MAX_PRG_BANKS = 32,
	parameter int MAX_CHR_BANKS = 32,
	localparam int RAM_AW = $clog2(PRG_RAM_BYTES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  opcode_t           opcode,
	input  logic [15:0]       bus_addr,
	input  logic [7:0]        write_data,
	input  logic [5:0]        bank_count,
	output result_t           res,
	output logic              ram_we,
	output logic              ram_re,
	output logic [RAM_AW-1:0] ram_idx
);

	localparam logic [14:0] RAM_1X = 15'(PRG_RAM_BYTES);
	localparam logic [14:0] RAM_2X = 15'(2 * PRG_RAM_BYTES);
	localparam logic [14:0] RAM_3X = 15'(3 * PRG_RAM_BYTES);
	localparam logic [5:0]  PRG_MAX = 6'(MAX_PRG_BANKS);

	logic [4:0] shifter_q, control_q, prg_low_q, prg_high_q, chr_low_q, chr_high_q;
	logic [2:0] writes_q;
	logic       high_last_q, ram_en_q;

	logic [4:0] shifter_d, control_d, prg_low_d, prg_high_d, chr_low_d, chr_high_d;
	logic [2:0] writes_d;
	logic       high_last_d, ram_en_d;

	logic [4:0]  sh_next, prg_bank, chr_bank, fixed_bank;
	logic [5:0]  n_clamped;
	logic [14:0] ram_off;
	logic        is_rom, is_ram;

	function automatic logic [4:0] prg_wrap(input logic [4:0] b);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			if (b == 5'(i)) r = 5'(i % MAX_PRG_BANKS);
		end
		return r;
	endfunction

	function automatic logic [4:0] chr_wrap(input logic [4:0] b);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			if (b == 5'(i)) r = 5'(i % MAX_CHR_BANKS);
		end
		return r;
	endfunction

	always_comb begin
		if (bank_count == 6'd0) n_clamped = 6'd1;
		else if (bank_count > PRG_MAX) n_clamped = PRG_MAX;
		else n_clamped = bank_count;
		fixed_bank = 5'(n_clamped - 6'd1);

		if (!bus_addr[14]) prg_bank = prg_wrap(prg_low_q);
		else if (high_last_q) prg_bank = fixed_bank;
		else prg_bank = prg_wrap(prg_high_q);

		chr_bank = chr_wrap(bus_addr[12] ? chr_high_q : chr_low_q);

		ram_off = {2'b00, bus_addr[12:0]};
		if (ram_off >= RAM_3X) ram_off = ram_off - RAM_3X;
		else if (ram_off >= RAM_2X) ram_off = ram_off - RAM_2X;
		else if (ram_off >= RAM_1X) ram_off = ram_off - RAM_1X;
	end

	assign is_rom  = bus_addr[15];
	assign is_ram  = bus_addr[15:13] == 3'b011;
	assign sh_next = {write_data[0], shifter_q[4:1]};
	assign ram_idx = ram_off[RAM_AW-1:0];

	always_comb begin
		shifter_d   = shifter_q;
		writes_d    = writes_q;
		control_d   = control_q;
		prg_low_d   = prg_low_q;
		prg_high_d  = prg_high_q;
		high_last_d = high_last_q;
		chr_low_d   = chr_low_q;
		chr_high_d  = chr_high_q;
		ram_en_d    = ram_en_q;
		res.target    = TGT_NONE;
		res.mem_addr  = '0;
		res.mem_write = 1'b0;
		ram_we = 1'b0;
		ram_re = 1'b0;
		case (opcode)
			OP_CPU_RD, OP_CPU_WR: begin
				if (is_rom) begin
					if (opcode == OP_CPU_RD) begin
						res.target   = TGT_PRG_ROM;
						res.mem_addr = {prg_bank, bus_addr[13:0]};
					end else if (write_data[7]) begin
						shifter_d = '0;
						writes_d  = '0;
						control_d = control_q | PRG_MODE3_BITS;
					end else if (writes_q >= 3'd4) begin
						shifter_d = sh_next;
						writes_d  = '0;
						unique case (reg_sel_t'(bus_addr[14:13]))
							SEL_CONTROL: control_d = sh_next;
							SEL_CHR0: begin
								if (!control_q[4]) begin
									chr_low_d  = {sh_next[4:1], 1'b0};
									chr_high_d = {sh_next[4:1], 1'b1};
								end else begin
									chr_low_d = sh_next;
								end
							end
							SEL_CHR1: begin
								if (control_q[4]) chr_high_d = sh_next;
							end
							SEL_PRG: begin
								if (!control_q[3]) begin
									prg_low_d   = {1'b0, sh_next[3:1], 1'b0};
									prg_high_d  = {1'b0, sh_next[3:1], 1'b1};
									high_last_d = 1'b0;
								end else if (!control_q[2]) begin
									prg_low_d   = '0;
									prg_high_d  = {1'b0, sh_next[3:0]};
									high_last_d = 1'b0;
								end else begin
									prg_low_d   = {1'b0, sh_next[3:0]};
									high_last_d = 1'b1;
								end
								ram_en_d = !sh_next[4];
							end
							default: ;
						endcase
					end else begin
						shifter_d = sh_next;
						writes_d  = writes_q + 3'd1;
					end
				end else if (is_ram) begin
					res.target   = TGT_PRG_RAM;
					res.mem_addr = {4'b0000, ram_off};
					ram_we = accept && (opcode == OP_CPU_WR);
					ram_re = accept && (opcode == OP_CPU_RD) && ram_en_q;
				end
			end
			default: begin
				res.target    = TGT_CHR;
				res.mem_addr  = {2'b00, chr_bank, bus_addr[11:0]};
				res.mem_write = opcode == OP_PPU_WR;
			end
		endcase
		res.mirroring = control_d[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shifter_q   <= '0;
			writes_q    <= '0;
			control_q   <= CONTROL_RST;
			prg_low_q   <= '0;
			prg_high_q  <= '0;
			high_last_q <= 1'b1;
			chr_low_q   <= '0;
			chr_high_q  <= CHR_HIGH_RST;
			ram_en_q    <= 1'b0;
		end else if (accept) begin
			shifter_q   <= shifter_d;
			writes_q    <= writes_d;
			control_q   <= control_d;
			prg_low_q   <= prg_low_d;
			prg_high_q  <= prg_high_d;
			high_last_q <= high_last_d;
			chr_low_q   <= chr_low_d;
			chr_high_q  <= chr_high_d;
			ram_en_q    <= ram_en_d;
		end
	end

endmodule

FILE: rtl/core/sbsm_ram.sv
// Work RAM, one write and one registered read per cycle.
module sbsm_ram #(
	parameter int DEPTH = 8192,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		if (re) rdata <= mem_q[addr];
	end

endmodule

FILE: rtl/core/serial_bank_switch_mapper.sv
// Top level of the serial bank switch mapper: stream ports, APB register, output stage.
//
// Each slave beat is one CPU or PPU bus access; each master beat is its
// translated result, exactly one per access, in order.
// Each beat's result is held in a single output register until the master side
// takes it. Throughput: one beat per cycle while the receiver takes results; the
// mapper registers update at the accept edge and the work RAM is written at that
// edge and read at it, so an access sees every access before it.
// s_tready is high whenever the output register is empty or is being taken,
// so a stalled receiver holds the result and the input stalls with it.
// The APB port holds prg_bank_count at address 0; pready is always high.
// Write it only while no beat is in flight.
// Reset brings the mapper registers to power-on values (control 0x0C, upper
// PRG bank fixed to the last bank) and empties the output register. Work RAM
// contents are not cleared; only written bytes are meaningful.
module serial_bank_switch_mapper import sbsm_pkg::*; #(
	parameter int PRG_RAM_BYTES = 8192,
	parameter int MAX_PRG_BANKS = 32,
	parameter int MAX_CHR_BANKS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // bus_addr[15:0], write_data[23:16]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // mem_addr[18:0], mem_write[19], ram_data[27:20],
	                               // mirroring[29:28], zero[31:30]
	output logic [1:0]  m_tuser,   // target[1:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RAM_AW = $clog2(PRG_RAM_BYTES);

	logic              accept;
	logic [5:0]        bank_count_q;
	result_t           res, res_s1;
	logic              valid_s1, rd_s1;
	logic              ram_we, ram_re;
	logic [RAM_AW-1:0] ram_idx;
	logic [7:0]        ram_rdata;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PRG_BANK_COUNT) ? {26'd0, bank_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_count_q <= PRG_BANK_COUNT_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_PRG_BANK_COUNT) begin
			bank_count_q <= pwdata[5:0];
		end
	end

	assign s_tready = !valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;

	sbsm_ctrl #(
		.PRG_RAM_BYTES(PRG_RAM_BYTES),
		.MAX_PRG_BANKS(MAX_PRG_BANKS),
		.MAX_CHR_BANKS(MAX_CHR_BANKS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.opcode    (opcode_t'(s_tuser)),
		.bus_addr  (s_tdata[15:0]),
		.write_data(s_tdata[23:16]),
		.bank_count(bank_count_q),
		.res       (res),
		.ram_we    (ram_we),
		.ram_re    (ram_re),
		.ram_idx   (ram_idx)
	);

	sbsm_ram #(
		.DEPTH(PRG_RAM_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_idx),
		.wdata(s_tdata[23:16]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
			rd_s1  <= ram_re;
		end
	end

	assign m_tvalid = valid_s1;
	assign m_tuser  = res_s1.target;
	assign m_tdata  = {2'b00, res_s1.mirroring, (rd_s1 ? ram_rdata : 8'd0),
		res_s1.mem_write, res_s1.mem_addr};

endmodule

FILE: tb/testbench.sv
// Self-checking stream testbench for the serial bank switch mapper with an in-line translation predictor.
`timescale 1ns / 1ps

module testbench;
	import sbsm_pkg::*;

	localparam logic [15:0] CPU_ROM_BASE = 16'h8000;
	localparam logic [15:0] RAM_BASE     = 16'h6000;
	localparam logic [15:0] RAM_LAST     = 16'h7FFF;
	localparam logic [2:0]  ADDR_PRG_BANK_COUNT = {REG_PRG_BANK_COUNT, 2'b00};
	localparam int          RAM_BYTES    = 8192;
	localparam int          MAX_BANKS    = 32;
	localparam int          DRAIN_CYCLES = 4;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          ITEMS_PER_PHASE = 175;

	typedef struct packed {
		opcode_t     op;
		logic [15:0] addr;
		logic [7:0]  data;
	} access_t;

	typedef struct packed {
		target_t     target;
		logic [18:0] mem_addr;
		logic        mem_write;
		logic [7:0]  ram_data;
		logic [1:0]  mirroring;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // bus_addr[15:0], write_data[23:16]
	logic [1:0]  s_tuser = '0;   // opcode[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // mem_addr[18:0], mem_write[19], ram_data[27:20], mirroring[29:28]
	logic [1:0]  m_tuser;        // target[1:0]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	serial_bank_switch_mapper dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mapper state as the predictor sees it
	logic [5:0] bank_count;
	logic [4:0] shift_reg;
	logic [2:0] shift_cnt;
	logic [4:0] ctrl;
	logic [4:0] prg_lo, prg_hi, chr_lo, chr_hi;
	logic       prg_hi_fixed;
	logic       ram_en;
	logic [7:0] work_ram [RAM_BYTES];

	access_t stimulus [$];
	reply_t  expected_replies [$];
	access_t beat_on_bus;
	logic    beat_taken = 1'b0;
	int      queued_count = 0;
	int      accepted_count = 0;
	int      results_seen = 0;
	int      mismatches = 0;
	int      cycle_count = 0;

	// generation-time view of which work RAM bytes hold data
	bit      ram_filled [RAM_BYTES];
	int      ram_filled_list [$];

	function automatic logic [4:0] last_prg_bank();
		logic [5:0] n;
		n = bank_count;
		if (n < 6'd1) n = 6'd1;
		if (n > 6'(MAX_BANKS)) n = 6'(MAX_BANKS);
		return 5'(n - 6'd1);
	endfunction

	task automatic load_bank_reg(input reg_sel_t sel, input logic [4:0] v);
		case (sel)
			SEL_CONTROL: ctrl = v;
			SEL_CHR0: begin
				if (!ctrl[4]) begin
					chr_lo = v & 5'h1E;
					chr_hi = (v & 5'h1E) + 5'd1;
				end else begin
					chr_lo = v;
				end
			end
			SEL_CHR1: begin
				if (ctrl[4]) chr_hi = v;
			end
			default: begin
				if (ctrl[3:2] <= 2'd1) begin
					prg_lo = v & 5'h0E;
					prg_hi = (v & 5'h0E) + 5'd1;
					prg_hi_fixed = 1'b0;
				end else if (ctrl[3:2] == 2'd2) begin
					prg_lo = 5'd0;
					prg_hi = v & 5'h0F;
					prg_hi_fixed = 1'b0;
				end else begin
					prg_lo = v & 5'h0F;
					prg_hi_fixed = 1'b1;
				end
				ram_en = !v[4];
			end
		endcase
	endtask

	task automatic translate_access(input access_t a, output reply_t r);
		logic [4:0]  bank;
		logic [12:0] idx;
		r = '0;
		r.target = TGT_NONE;
		if (a.op == OP_CPU_RD || a.op == OP_CPU_WR) begin
			if (a.addr >= CPU_ROM_BASE) begin
				if (a.op == OP_CPU_RD) begin
					if (!a.addr[14]) bank = prg_lo;
					else if (prg_hi_fixed) bank = last_prg_bank();
					else bank = prg_hi;
					r.target = TGT_PRG_ROM;
					r.mem_addr = {bank, a.addr[13:0]};
				end else if (a.data[7]) begin
					shift_reg = '0;
					shift_cnt = '0;
					ctrl = ctrl | PRG_MODE3_BITS;
				end else begin
					shift_reg = {a.data[0], shift_reg[4:1]};
					shift_cnt = shift_cnt + 3'd1;
					if (shift_cnt >= 3'd5) begin
						shift_cnt = '0;
						load_bank_reg(reg_sel_t'(a.addr[14:13]), shift_reg);
					end
				end
			end else if (a.addr >= RAM_BASE) begin
				idx = 13'(a.addr - RAM_BASE);
				r.target = TGT_PRG_RAM;
				r.mem_addr = 19'(idx);
				if (a.op == OP_CPU_WR) work_ram[idx] = a.data;
				else if (ram_en) r.ram_data = work_ram[idx];
			end
		end else begin
			bank = a.addr[12] ? chr_hi : chr_lo;
			r.target = TGT_CHR;
			r.mem_addr = {2'b00, bank, a.addr[11:0]};
			r.mem_write = (a.op == OP_PPU_WR);
		end
		r.mirroring = ctrl[1:0];
	endtask

	// accept side: predict each input beat as it is taken
	always @(posedge clk) begin : accept_side
		reply_t r;
		if (arst_n && s_tvalid && s_tready) begin
			translate_access(beat_on_bus, r);
			expected_replies.push_back(r);
			accepted_count++;
			beat_taken = 1'b1;
		end
	end

	// driver: bursts of beats with random gaps
	int burst_left = 1;
	int gap_left = 0;
	always @(negedge clk) begin
		if (!(s_tvalid && !beat_taken)) begin
			beat_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (stimulus.size() == 0) begin
				s_tvalid <= 1'b0;
			end else begin
				beat_on_bus = stimulus.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {beat_on_bus.data, beat_on_bus.addr};
				s_tuser <= beat_on_bus.op;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// receiver: stall pattern changes every so often, plus one long hold-off and rare random ones
	int  hold_left = 0;
	int  rx_mode = 0;
	int  rx_cycle = 0;
	bit  long_hold_done = 1'b0;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!long_hold_done && results_seen >= 100) begin
			long_hold_done = 1'b1;
			hold_left = 80;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 999) == 0) begin
			hold_left = $urandom_range(20, 60);
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
		rx_cycle++;
		if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 2);
	end

	// monitor
	always @(posedge clk) begin : result_check
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_replies.size() == 0) begin
				$error("result beat with no access outstanding");
				mismatches++;
			end else begin
				want = expected_replies.pop_front();
				if (m_tuser !== want.target) begin
					$error("target: expected %0d, got %0d", want.target, m_tuser);
					mismatches++;
				end
				if (m_tdata[18:0] !== want.mem_addr) begin
					$error("mem_addr: expected %h, got %h", want.mem_addr, m_tdata[18:0]);
					mismatches++;
				end
				if (m_tdata[19] !== want.mem_write) begin
					$error("mem_write: expected %0d, got %0d", want.mem_write, m_tdata[19]);
					mismatches++;
				end
				if (m_tdata[27:20] !== want.ram_data) begin
					$error("ram_data: expected %h, got %h", want.ram_data, m_tdata[27:20]);
					mismatches++;
				end
				if (m_tdata[29:28] !== want.mirroring) begin
					$error("mirroring: expected %0d, got %0d", want.mirroring, m_tdata[29:28]);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic push_access(input opcode_t op, input logic [15:0] a, input logic [7:0] d);
		access_t item;
		int idx;
		item.op = op;
		item.addr = a;
		item.data = d;
		if (op == OP_CPU_WR && a >= RAM_BASE && a <= RAM_LAST) begin
			idx = int'(a - RAM_BASE) % RAM_BYTES;
			if (!ram_filled[idx]) begin
				ram_filled[idx] = 1'b1;
				ram_filled_list.push_back(idx);
			end
		end
		stimulus.push_back(item);
		queued_count++;
	endtask

	task automatic push_serial_write(input reg_sel_t sel, input logic [4:0] v, input int bits);
		for (int i = 0; i < bits; i++)
			push_access(OP_CPU_WR, {1'b1, sel, 13'($urandom)}, {1'b0, 6'($urandom), v[i]});
	endtask

	task automatic push_random_access();
		int idx;
		case ($urandom_range(0, 9))
			0, 1: push_access(OP_CPU_RD, CPU_ROM_BASE | 16'($urandom_range(0, 16'h7FFF)),
				8'($urandom));
			2, 3: push_access(opcode_t'($urandom_range(2, 3)), 16'($urandom), 8'($urandom));
			4: push_access(OP_CPU_WR, RAM_BASE + 16'($urandom_range(0, RAM_BYTES - 1)),
				8'($urandom));
			5, 6: begin
				if (ram_filled_list.size() == 0) begin
					push_access(OP_CPU_WR, RAM_BASE + 16'($urandom_range(0, RAM_BYTES - 1)),
						8'($urandom));
				end else begin
					idx = ram_filled_list[$urandom_range(0, ram_filled_list.size() - 1)];
					push_access(OP_CPU_RD, RAM_BASE + 16'(idx), 8'($urandom));
				end
			end
			7: push_access(opcode_t'($urandom_range(0, 1)), 16'($urandom_range(0, 16'h5FFF)),
				8'($urandom));
			default: push_access(OP_CPU_RD, CPU_ROM_BASE | 16'($urandom_range(0, 16'h7FFF)),
				8'($urandom));
		endcase
	endtask

	task automatic push_random_sequence();
		int n;
		n = $urandom_range(0, 9);
		if (n < 5) begin
			push_serial_write(reg_sel_t'($urandom_range(0, 3)), 5'($urandom), 5);
			repeat ($urandom_range(1, 6)) push_random_access();
		end else if (n == 5) begin
			// aborted shift sequence
			push_serial_write(reg_sel_t'($urandom_range(0, 3)), 5'($urandom),
				$urandom_range(0, 4));
			push_access(OP_CPU_WR, CPU_ROM_BASE | 16'($urandom_range(0, 16'h7FFF)),
				8'h80 | 8'($urandom));
		end else begin
			repeat ($urandom_range(1, 8)) push_random_access();
		end
	endtask

	task automatic wait_drained();
		while (accepted_count != queued_count || expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_bank_count(input logic [5:0] n);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_PRG_BANK_COUNT;
		pwdata <= 32'(n);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		bank_count = n;
	endtask

	logic [5:0] count_settings [8] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd33, 6'd17, 6'd2, 6'd8};

	initial begin
		int target_items;
		bank_count = PRG_BANK_COUNT_RST;
		shift_reg = '0;
		shift_cnt = '0;
		ctrl = CONTROL_RST;
		prg_lo = '0;
		prg_hi = '0;
		prg_hi_fixed = 1'b1;
		chr_lo = '0;
		chr_hi = CHR_HIGH_RST;
		ram_en = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset values, address extremes, ignored accesses, RAM enable
		push_access(OP_CPU_RD, 16'h8000, 8'h00);
		push_access(OP_CPU_RD, 16'hFFFF, 8'hFF);
		push_access(OP_CPU_WR, 16'hFFFF, 8'hFF);
		push_access(OP_PPU_RD, 16'h0000, 8'h00);
		push_access(OP_PPU_RD, 16'h1FFF, 8'hFF);
		push_access(OP_PPU_WR, 16'hFFFF, 8'hA5);
		push_access(OP_CPU_RD, 16'h0000, 8'h00);
		push_access(OP_CPU_WR, 16'h5FFF, 8'hFF);
		push_access(OP_CPU_WR, 16'h6000, 8'hFF);
		push_access(OP_CPU_WR, 16'h7FFF, 8'h00);
		push_access(OP_CPU_RD, 16'h6000, 8'h00);
		push_serial_write(SEL_PRG, 5'h00, 5);
		push_access(OP_CPU_RD, 16'h7FFF, 8'h00);
		push_serial_write(SEL_CHR1, 5'h1F, 5);
		push_access(OP_PPU_RD, 16'h1000, 8'h00);
		push_access(OP_CPU_RD, 16'h6000, 8'h00);
		wait_drained();

		foreach (count_settings[p]) begin
			write_bank_count(count_settings[p]);
			target_items = queued_count + ITEMS_PER_PHASE;
			while (queued_count < target_items) push_random_sequence();
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (expected_replies.size() != 0) begin
			$error("%0d expected results never arrived", expected_replies.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
